>>> rtl/incremental_osa_edit_distance_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the incremental OSA edit distance block
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_OSA_EDIT_DISTANCE_TOP_ASSERT_SVH
`define INCREMENTAL_OSA_EDIT_DISTANCE_TOP_ASSERT_SVH

// same-cycle implication
`define IOED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IOED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ioed_pkg.sv
// ----------------------------------------------------------------------------
// ioed_pkg
// Sizes, codes, item and result types for the incremental OSA edit distance.
// ----------------------------------------------------------------------------
package ioed_pkg;

  // store sizes
  localparam int NEEDLE_MAX = 32;
  localparam int HAY_MAX    = 64;
  localparam int COLS       = NEEDLE_MAX + 1;
  localparam int TBL_DEPTH  = (HAY_MAX + 1) * COLS;

  // widths
  localparam int NAW = $clog2(NEEDLE_MAX);      // needle store address
  localparam int HAW = $clog2(HAY_MAX);         // hay store address
  localparam int TAW = $clog2(TBL_DEPTH);       // table address
  localparam int CW  = $clog2(NEEDLE_MAX + 1);  // column index / needle length
  localparam int VW  = 7;                       // distances, lengths, positions
  localparam int CHW = 8;                       // characters
  localparam int RW  = 6;                       // config register width

  // action codes
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_REWIND = 2'd2;

  // register index codes
  localparam logic REG_NEEDLE_LENGTH = 1'b0;
  localparam logic REG_MAX_DISTANCE  = 1'b1;

  typedef struct packed {
    logic [1:0]     action;
    logic [VW-1:0]  position;
    logic [CHW-1:0] character;
  } item_t;

  typedef struct packed {
    logic [VW-1:0] hay_length;
    logic          overflow;
    logic [VW-1:0] full_distance;
    logic [VW-1:0] prefix_distance;
  } result_t;

  typedef struct packed {
    logic [RW-1:0] needle_length;
    logic [RW-1:0] max_distance;
    logic          clear;          // a register was written: drop the hay
  } cfg_t;

  // operands of one table cell
  typedef struct packed {
    logic [VW-1:0] up;
    logic [VW-1:0] left;
    logic [VW-1:0] diag;
    logic [VW-1:0] trans;
    logic          mismatch;
    logic          trans_en;
  } cell_in_t;

  // flat table address of D[row][col]
  function automatic logic [TAW-1:0] tbl_addr(input logic [VW-1:0] row,
                                               input logic [CW-1:0] col);
    tbl_addr = TAW'(row) * TAW'(COLS) + TAW'(col);
  endfunction

endpackage

>>> rtl/incremental_osa_edit_distance_top.sv
// ----------------------------------------------------------------------------
// incremental_osa_edit_distance_top
// Incremental restricted Damerau (OSA) edit distance between a loaded needle
// and a hay string grown one character per append.
//
//   channel  | dir | handshake               | content
//   ---------+-----+-------------------------+----------------------------------
//   s_       | in  | s_tvalid / s_tready     | action, position, character
//   m_       | out | m_tvalid / m_tready     | distances, overflow, hay length
//   apb      | in  | psel, penable, pwrite   | needle_length (0x0), max_distance (0x4)
//
// Load, rewind, rejected append or append with an empty needle: execute,
// table read and result states. Other appends sweep a new table row between
// execute and table read, over needle_length capped at 32 columns: one table
// column per cycle through the single cell unit, reads issued one ahead.
// Reset is synchronous; stores are undefined until written, no clearing pass.
// A finished result waits in the output register; the next transaction is
// taken meanwhile, and the core holds only if that register is still full.
// ----------------------------------------------------------------------------
module incremental_osa_edit_distance_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [6:0] position, [14:7] character, [15] zero
  input  logic [1:0]  s_tuser,   // [1:0] action
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [6:0] prefix_distance, [13:7] full_distance,
                                 // [20:14] hay_length, [23:21] zero
  output logic        m_tuser,   // [0] overflow
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ioed_pkg::RW-1:0] needle_length;
  logic [ioed_pkg::RW-1:0] max_distance;
  logic                    cfg_wr;
  ioed_pkg::cfg_t          cfg;
  ioed_pkg::item_t         item;
  ioed_pkg::result_t       res;
  ioed_pkg::result_t       out_q;
  logic                    res_valid;
  logic                    res_ready;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_length <= '0;
      max_distance  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        ioed_pkg::REG_NEEDLE_LENGTH: needle_length <= pwdata[ioed_pkg::RW-1:0];
        ioed_pkg::REG_MAX_DISTANCE:  max_distance  <= pwdata[ioed_pkg::RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ioed_pkg::REG_NEEDLE_LENGTH: prdata = 32'(needle_length);
      ioed_pkg::REG_MAX_DISTANCE:  prdata = 32'(max_distance);
      default:                     prdata = '0;
    endcase
  end

  assign cfg.needle_length = needle_length;
  assign cfg.max_distance  = max_distance;
  assign cfg.clear         = cfg_wr;

  // input unpacking
  assign item.action    = s_tuser;
  assign item.position  = s_tdata[6:0];
  assign item.character = s_tdata[14:7];

  ioed_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_tdata = {3'b000, out_q.hay_length, out_q.full_distance,
                    out_q.prefix_distance};
  assign m_tuser = out_q.overflow;

endmodule

>>> rtl/ioed_cell.sv
// ----------------------------------------------------------------------------
// ioed_cell
// Shared cell unit: minimum over insertion, deletion, substitution and
// adjacent transposition for one table entry.
// ----------------------------------------------------------------------------
module ioed_cell (
  input  ioed_pkg::cell_in_t          ci,
  output logic [ioed_pkg::VW-1:0]     best
);

  logic [ioed_pkg::VW:0] c_up;
  logic [ioed_pkg::VW:0] c_left;
  logic [ioed_pkg::VW:0] c_diag;
  logic [ioed_pkg::VW:0] c_trans;
  logic [ioed_pkg::VW:0] m0;
  logic [ioed_pkg::VW:0] m1;

  // candidate costs, one bit wider
  assign c_up    = {1'b0, ci.up} + (ioed_pkg::VW + 1)'(1);
  assign c_left  = {1'b0, ci.left} + (ioed_pkg::VW + 1)'(1);
  assign c_diag  = {1'b0, ci.diag} + (ioed_pkg::VW + 1)'(ci.mismatch);
  assign c_trans = {1'b0, ci.trans} + (ioed_pkg::VW + 1)'(1);

  // minimum tree
  always_comb begin
    m0 = (c_up < c_left) ? c_up : c_left;
    m1 = (c_diag < m0) ? c_diag : m0;
    if (ci.trans_en && (c_trans < m1)) begin
      m1 = c_trans;
    end
  end

  assign best = m1[ioed_pkg::VW-1:0];

endmodule

>>> rtl/ioed_core.sv
// ----------------------------------------------------------------------------
// ioed_core
// Sequencer, needle/hay/table stores and row sweep through the shared cell
// unit. One column per cycle, with table reads registered in the cycle before the compute.
// ----------------------------------------------------------------------------
`include "incremental_osa_edit_distance_top_assert.svh"

module ioed_core (
  input  logic              clk,
  input  logic              rst,
  input  ioed_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  ioed_pkg::item_t   in_item,
  output logic              res_valid,
  input  logic              res_ready,
  output ioed_pkg::result_t res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_ROW  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // latched item
  logic [1:0]                   act;
  logic [ioed_pkg::VW-1:0]      pos;
  logic [ioed_pkg::CHW-1:0]     chr;

  logic [ioed_pkg::VW-1:0]      hay_count;
  logic                         ovf;

  // row sweep
  logic [ioed_pkg::VW-1:0]      row_i;
  logic [ioed_pkg::CW-1:0]      ji;     // column being issued
  logic [ioed_pkg::CW-1:0]      jc;     // column being computed
  logic                         pend;
  logic [ioed_pkg::VW-1:0]      left_q;
  logic [ioed_pkg::VW-1:0]      diag_q;
  logic [ioed_pkg::CHW-1:0]     nd_prev;

  // memories and read data
  logic [ioed_pkg::CHW-1:0] needle_mem [ioed_pkg::NEEDLE_MAX];
  logic [ioed_pkg::CHW-1:0] hay_mem    [ioed_pkg::HAY_MAX];
  logic [ioed_pkg::VW-1:0]  tbl_mem    [ioed_pkg::TBL_DEPTH];
  logic [ioed_pkg::CHW-1:0] nd_rd;
  logic [ioed_pkg::CHW-1:0] hay_rd;
  logic [ioed_pkg::VW-1:0]  rd_a;
  logic [ioed_pkg::VW-1:0]  rd_b;

  logic [ioed_pkg::CW-1:0]  eff_n;
  logic [ioed_pkg::VW-1:0]  hay_lim;
  logic [ioed_pkg::VW-1:0]  lim_sum;
  logic [ioed_pkg::CW-1:0]  min_hn;
  logic                     at_limit;
  logic                     issue;
  logic [ioed_pkg::TAW-1:0] ra;
  logic [ioed_pkg::TAW-1:0] rb;
  logic                     tbl_re;
  logic                     nd_we;
  logic                     hay_we;
  ioed_pkg::cell_in_t       ci;
  logic [ioed_pkg::VW-1:0]  best;

  // effective needle length and hay limit
  assign eff_n    = (cfg.needle_length > ioed_pkg::CW'(ioed_pkg::NEEDLE_MAX)) ?
                    ioed_pkg::CW'(ioed_pkg::NEEDLE_MAX) : cfg.needle_length;
  assign lim_sum  = ioed_pkg::VW'(eff_n) + ioed_pkg::VW'(cfg.max_distance);
  assign hay_lim  = (lim_sum > ioed_pkg::VW'(ioed_pkg::HAY_MAX)) ?
                    ioed_pkg::VW'(ioed_pkg::HAY_MAX) : lim_sum;
  assign at_limit = (hay_count >= hay_lim);
  assign min_hn   = (hay_count < ioed_pkg::VW'(eff_n)) ?
                    ioed_pkg::CW'(hay_count) : eff_n;

  assign in_ready  = (state == S_IDLE);
  assign issue     = (state == S_ROW) && (ji <= eff_n);
  assign nd_we     = (state == S_EXEC) && (act == ioed_pkg::ACT_LOAD) &&
                     (pos < ioed_pkg::VW'(ioed_pkg::NEEDLE_MAX));
  assign hay_we    = (state == S_EXEC) && (act == ioed_pkg::ACT_APPEND) && !at_limit;
  assign tbl_re    = (state == S_ROW) || (state == S_RD);

  // table read addresses: row sweep or final result lookup
  always_comb begin
    ra = '0;
    rb = '0;
    if (state == S_RD) begin
      ra = ioed_pkg::tbl_addr(hay_count, min_hn);
      rb = ioed_pkg::tbl_addr(hay_count, eff_n);
    end else if (issue) begin
      ra = ioed_pkg::tbl_addr(row_i - ioed_pkg::VW'(1), ji);
      if ((row_i > ioed_pkg::VW'(1)) && (ji > ioed_pkg::CW'(1))) begin
        rb = ioed_pkg::tbl_addr(row_i - ioed_pkg::VW'(2), ji - ioed_pkg::CW'(2));
      end
    end
  end

  // cell operands, with row 0 and column 0 supplied as constants
  always_comb begin
    ci.up       = (row_i == ioed_pkg::VW'(1)) ? ioed_pkg::VW'(jc) : rd_a;
    ci.left     = (jc == ioed_pkg::CW'(1)) ? row_i : left_q;
    ci.diag     = (jc == ioed_pkg::CW'(1)) ? (row_i - ioed_pkg::VW'(1)) : diag_q;
    ci.mismatch = (chr != nd_rd);
    ci.trans_en = (row_i > ioed_pkg::VW'(1)) && (jc > ioed_pkg::CW'(1)) &&
                  (chr == nd_prev) && (hay_rd == nd_rd);
    if (row_i == ioed_pkg::VW'(2)) begin
      ci.trans = ioed_pkg::VW'(jc) - ioed_pkg::VW'(2);
    end else if (jc == ioed_pkg::CW'(2)) begin
      ci.trans = row_i - ioed_pkg::VW'(2);
    end else begin
      ci.trans = rd_b;
    end
  end

  ioed_cell u_cell (
    .ci   (ci),
    .best (best)
  );

  // needle store
  always_ff @(posedge clk) begin
    if (nd_we) begin
      needle_mem[pos[ioed_pkg::NAW-1:0]] <= chr;
    end
    if (issue) begin
      nd_rd <= needle_mem[ioed_pkg::NAW'(ji - ioed_pkg::CW'(1))];
    end
  end

  // hay store: previous character fetched while the new one is written
  always_ff @(posedge clk) begin
    if (hay_we) begin
      hay_mem[hay_count[ioed_pkg::HAW-1:0]] <= chr;
    end
    if (state == S_EXEC) begin
      hay_rd <= hay_mem[hay_count[ioed_pkg::HAW-1:0] - ioed_pkg::HAW'(1)];
    end
  end

  // distance table: one write, two reads
  always_ff @(posedge clk) begin
    if ((state == S_ROW) && pend) begin
      tbl_mem[ioed_pkg::tbl_addr(row_i, jc)] <= best;
    end
    if (tbl_re) begin
      rd_a <= tbl_mem[ra];
      rd_b <= tbl_mem[rb];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (hay_we && (eff_n != '0)) state_next = S_ROW;
        else                          state_next = S_RD;
      end
      S_ROW: begin
        if (pend && (jc == eff_n)) state_next = S_RD;
      end
      S_RD: begin
        state_next = S_RES;
      end
      S_RES: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hay_count <= '0;
      ovf       <= 1'b0;
      pend      <= 1'b0;
      ji        <= '0;
      jc        <= '0;
      row_i     <= '0;
    end else begin
      state <= state_next;
      if (cfg.clear) begin
        hay_count <= '0;
      end
      if (state == S_EXEC) begin
        ovf <= 1'b0;
        case (act)
          ioed_pkg::ACT_LOAD: begin
            hay_count <= '0;
          end
          ioed_pkg::ACT_APPEND: begin
            if (at_limit) begin
              ovf <= 1'b1;
            end else begin
              hay_count <= hay_count + ioed_pkg::VW'(1);
            end
          end
          ioed_pkg::ACT_REWIND: begin
            if (pos < hay_count) hay_count <= pos;
          end
          default: ;
        endcase
        row_i <= hay_count + ioed_pkg::VW'(1);
        ji    <= ioed_pkg::CW'(1);
        pend  <= 1'b0;
      end
      if (state == S_ROW) begin
        pend <= issue;
        jc   <= ji;
        if (issue) ji <= ji + ioed_pkg::CW'(1);
      end
    end
  end

  // item capture and sweep datapath
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act <= in_item.action;
      pos <= in_item.position;
      chr <= in_item.character;
    end
    if ((state == S_ROW) && pend) begin
      left_q  <= best;
      diag_q  <= ci.up;
      nd_prev <= nd_rd;
    end
  end

  // result
  assign res_valid           = (state == S_RES);
  assign res.hay_length      = hay_count;
  assign res.overflow        = ovf;
  assign res.prefix_distance = (hay_count == '0) ? '0 :
                               (min_hn == '0) ? hay_count : rd_a;
  assign res.full_distance   = (hay_count == '0) ? ioed_pkg::VW'(eff_n) :
                               (eff_n == '0) ? hay_count : rd_b;

  `IOED_ASSERT_IMP(a_hay_cap, 1'b1, hay_count <= hay_lim, "hay length beyond limit")
  `IOED_ASSERT_IMP(a_issue_bound, state == S_ROW, ji <= eff_n + ioed_pkg::CW'(1), "column issue overran row")
  `IOED_ASSERT_NXT(a_hay_grow, hay_we, hay_count == $past(hay_count) + ioed_pkg::VW'(1), "append did not grow hay")
  `IOED_ASSERT_IMP(a_ovf_append, (state == S_RES) && ovf, act == ioed_pkg::ACT_APPEND, "overflow on non-append")

endmodule

>>> test/incremental_osa_edit_distance_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// incremental_osa_edit_distance_top_test
// Self-checking bench for the incremental OSA edit distance block. A local
// model keeps the needle, the hay and the distance rows, and predicts each
// result when its input transaction is accepted. The results are checked in
// order as they leave the block. The stimulus has three parts: directed
// cases, register extremes, and random trie-style walks (grow, backtrack,
// regrow) with noise mixed in. The sender idles in bursts and the receiver
// stalls on patterns of its own.
// ----------------------------------------------------------------------------
module incremental_osa_edit_distance_top_test;

  localparam logic [1:0] ACT_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam int         SETTLE_CYCLES = 45;     // longest append latency plus margin
  localparam int         RANDOM_ITEMS  = 1470;

  typedef enum {READY_ALWAYS, READY_RANDOM, READY_PATTERN, READY_SPARSE} ready_mode_t;

  // DUT ports
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // [6:0] position, [14:7] character, [15] zero
  logic [1:0]  s_tuser  = '0;   // [1:0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [6:0] prefix, [13:7] full, [20:14] hay length
  logic        m_tuser;         // [0] overflow
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // predicted state of the block
  logic [ioed_pkg::CHW-1:0] needle_chars [ioed_pkg::NEEDLE_MAX];
  logic [ioed_pkg::CHW-1:0] hay_chars    [ioed_pkg::HAY_MAX];
  logic [ioed_pkg::VW-1:0]  dist_rows    [ioed_pkg::HAY_MAX+1][ioed_pkg::COLS];
  int                       hay_len;
  logic [ioed_pkg::RW-1:0]  needle_len_q;
  logic [ioed_pkg::RW-1:0]  slack_q;

  // expected results in flight
  ioed_pkg::result_t pending_distances [$];
  ioed_pkg::result_t head_result;

  int error_count = 0;
  int cycle_count = 0;
  int items_sent  = 0;

  // sender burst control
  bit idle_on    = 1'b0;
  int burst_left = 0;

  // character pool for the current walk
  logic [ioed_pkg::CHW-1:0] alphabet [4];
  int                       alphabet_size = 2;
  bit                       wide_chars    = 1'b0;

  // receiver stall state
  ready_mode_t ready_mode    = READY_ALWAYS;
  int          ready_hold    = 0;
  logic [7:0]  ready_pattern = 8'hFF;

  incremental_osa_edit_distance_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  function automatic int effective_needle();
    return (needle_len_q > ioed_pkg::NEEDLE_MAX) ? ioed_pkg::NEEDLE_MAX :
           int'(needle_len_q);
  endfunction

  // row 0 and column 0 are fixed
  function automatic int dist_at(int row, int col);
    if (row == 0) return col;
    if (col == 0) return row;
    return int'(dist_rows[row][col]);
  endfunction

  task automatic advance_alignment(input logic [1:0] act,
                                   input logic [ioed_pkg::VW-1:0] pos,
                                   input logic [ioed_pkg::CHW-1:0] ch,
                                   output ioed_pkg::result_t res);
    int   n;
    int   lim;
    int   row;
    int   col;
    int   best;
    int   cand;
    logic ovf;
    n   = effective_needle();
    ovf = 1'b0;
    case (act)
      ioed_pkg::ACT_LOAD: begin
        if (pos < ioed_pkg::NEEDLE_MAX) needle_chars[pos] = ch;
        hay_len = 0;
      end
      ioed_pkg::ACT_APPEND: begin
        lim = n + int'(slack_q);
        if (lim > ioed_pkg::HAY_MAX) lim = ioed_pkg::HAY_MAX;
        if (hay_len >= lim) begin
          ovf = 1'b1;
        end else begin
          hay_chars[hay_len] = ch;
          hay_len++;
          row = hay_len;
          // new table row, left to right
          for (col = 1; col <= n; col++) begin
            best = dist_at(row - 1, col) + 1;
            cand = dist_at(row, col - 1) + 1;
            if (cand < best) best = cand;
            cand = dist_at(row - 1, col - 1) + ((ch != needle_chars[col-1]) ? 1 : 0);
            if (cand < best) best = cand;
            // adjacent transposition
            if (row > 1 && col > 1 && ch == needle_chars[col-2] &&
                hay_chars[row-2] == needle_chars[col-1]) begin
              cand = dist_at(row - 2, col - 2) + 1;
              if (cand < best) best = cand;
            end
            dist_rows[row][col] = ioed_pkg::VW'(best);
          end
        end
      end
      ioed_pkg::ACT_REWIND: begin
        if (pos < hay_len) hay_len = int'(pos);
      end
      default: ;
    endcase
    res.prefix_distance = ioed_pkg::VW'(dist_at(hay_len, (hay_len < n) ? hay_len : n));
    res.full_distance   = ioed_pkg::VW'(dist_at(hay_len, n));
    res.overflow        = ovf;
    res.hay_length      = ioed_pkg::VW'(hay_len);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_distances.size() == 0) begin
        $error("result transaction with nothing expected, m_tdata %h", m_tdata);
        error_count++;
      end else begin
        head_result = pending_distances.pop_front();
        check_field("prefix_distance", int'(head_result.prefix_distance),
                    int'(m_tdata[6:0]));
        check_field("full_distance", int'(head_result.full_distance),
                    int'(m_tdata[13:7]));
        check_field("hay_length", int'(head_result.hay_length),
                    int'(m_tdata[20:14]));
        check_field("overflow", int'(head_result.overflow), int'(m_tuser));
      end
    end
  end

  // receiver stalls: mode and pattern are redrawn when the hold counter runs out
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode    = ready_mode_t'($urandom_range(0, 3));
      ready_hold    = $urandom_range(50, 400);
      ready_pattern = 8'($urandom()) | 8'h01;
    end else begin
      ready_hold--;
    end
    case (ready_mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
      READY_PATTERN: begin
        m_tready      <= ready_pattern[0];
        ready_pattern  = {ready_pattern[0], ready_pattern[7:1]};
      end
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("incremental_osa_edit_distance_top_test NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks (called at a rising edge)
  // ---------------------------------------------------------------------------

  // one input transaction; prediction happens at acceptance
  task automatic send_item(input logic [1:0] act, input logic [ioed_pkg::VW-1:0] pos,
                           input logic [ioed_pkg::CHW-1:0] ch);
    ioed_pkg::result_t res;
    if (idle_on && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, ch, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_alignment(act, pos, ch, res);
    pending_distances.push_back(res);
    items_sent++;
  endtask

  // let every result come back, then let the core settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [ioed_pkg::RW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {26'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == ioed_pkg::REG_NEEDLE_LENGTH) needle_len_q = value;
    else slack_q = value;
    hay_len = 0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read(input logic idx, input logic [ioed_pkg::RW-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field(idx == ioed_pkg::REG_NEEDLE_LENGTH ? "needle_length" : "max_distance",
                int'(want), int'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [ioed_pkg::RW-1:0] nl,
                            input logic [ioed_pkg::RW-1:0] md);
    drain_results();
    reg_write(ioed_pkg::REG_NEEDLE_LENGTH, nl);
    reg_write(ioed_pkg::REG_MAX_DISTANCE, md);
    reg_read(ioed_pkg::REG_NEEDLE_LENGTH, nl);
    reg_read(ioed_pkg::REG_MAX_DISTANCE, md);
  endtask

  function automatic logic [ioed_pkg::CHW-1:0] pick_char();
    if (wide_chars) return ioed_pkg::CHW'($urandom());
    return alphabet[$urandom_range(0, alphabet_size - 1)];
  endfunction

  // grow, backtrack and regrow the hay like a trie walk, with some noise
  task automatic search_walk(input int count);
    int                       k;
    int                       r;
    int                       idx;
    int                       n;
    logic [ioed_pkg::CHW-1:0] ch;
    n = effective_needle();
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // append, often a character near the aligned needle position
        if (n > 0 && $urandom_range(0, 1) == 1) begin
          idx = hay_len + $urandom_range(0, 2) - 1;
          if (idx < 0) idx = 0;
          if (idx >= n) idx = n - 1;
          ch = needle_chars[idx];
        end else begin
          ch = pick_char();
        end
        send_item(ioed_pkg::ACT_APPEND, ioed_pkg::VW'($urandom()), ch);
      end else if (r < 80) begin
        send_item(ioed_pkg::ACT_REWIND, ioed_pkg::VW'($urandom_range(0, hay_len)),
                  ioed_pkg::CHW'($urandom()));
      end else if (r < 85) begin
        send_item(ioed_pkg::ACT_REWIND, ioed_pkg::VW'($urandom_range(0, 127)),
                  ioed_pkg::CHW'($urandom()));
      end else if (r < 90) begin
        send_item(ioed_pkg::ACT_LOAD, ioed_pkg::VW'($urandom_range(0, 127)), pick_char());
      end else if (r < 94) begin
        send_item(ACT_UNUSED, ioed_pkg::VW'($urandom()), ioed_pkg::CHW'($urandom()));
      end else begin
        send_item(ioed_pkg::ACT_APPEND, ioed_pkg::VW'($urandom()),
                  ioed_pkg::CHW'($urandom()));
      end
    end
  endtask

  // new settings, a fresh needle, then a walk
  task automatic run_phase(input logic [ioed_pkg::RW-1:0] nl,
                           input logic [ioed_pkg::RW-1:0] md,
                           input int walk_items);
    int p;
    set_config(nl, md);
    idle_on       = ($urandom_range(0, 4) != 0);
    wide_chars    = ($urandom_range(0, 3) == 0);
    alphabet_size = $urandom_range(2, 4);
    for (p = 0; p < 4; p++) alphabet[p] = ioed_pkg::CHW'($urandom());
    for (p = 0; p < effective_needle(); p++) begin
      send_item(ioed_pkg::ACT_LOAD, ioed_pkg::VW'(p), pick_char());
    end
    search_walk(walk_items);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    idle_on = 1'b0;
    // hay limit is zero out of reset
    send_item(ioed_pkg::ACT_APPEND, 7'h00, 8'h00);
    send_item(ACT_UNUSED, 7'h7F, 8'hFF);
    send_item(ioed_pkg::ACT_REWIND, 7'h7F, 8'hFF);
    set_config(6'd3, 6'd1);
    // needle 00 FF 5A, plus loads outside the used range
    send_item(ioed_pkg::ACT_LOAD, 7'd0, 8'h00);
    send_item(ioed_pkg::ACT_LOAD, 7'd1, 8'hFF);
    send_item(ioed_pkg::ACT_LOAD, 7'd2, 8'h5A);
    send_item(ioed_pkg::ACT_LOAD, 7'd31, 8'hA5);
    send_item(ioed_pkg::ACT_LOAD, 7'h7F, 8'h33);
    // swapped pair, match, one extra, then the limit
    send_item(ioed_pkg::ACT_APPEND, 7'h00, 8'hFF);
    send_item(ioed_pkg::ACT_APPEND, 7'h7F, 8'h00);
    send_item(ioed_pkg::ACT_APPEND, 7'h00, 8'h5A);
    send_item(ioed_pkg::ACT_APPEND, 7'h00, 8'h11);
    send_item(ioed_pkg::ACT_APPEND, 7'h00, 8'h22);
    // rewinds: past the end, partial, to empty
    send_item(ioed_pkg::ACT_REWIND, 7'h7F, 8'h00);
    send_item(ioed_pkg::ACT_REWIND, 7'd2, 8'h00);
    send_item(ioed_pkg::ACT_APPEND, 7'h00, 8'h5A);
    send_item(ioed_pkg::ACT_REWIND, 7'd0, 8'h00);
    send_item(ioed_pkg::ACT_APPEND, 7'h00, 8'h5A);
    send_item(ACT_UNUSED, 7'h00, 8'h00);
  endtask

  task automatic test_register_extremes();
    run_phase(6'd0, 6'd0, 30);
    run_phase(6'd0, 6'd63, 40);
    run_phase(6'd1, 6'd0, 30);
    run_phase(6'd32, 6'd0, 40);
    run_phase(6'd32, 6'd32, 40);
    run_phase(6'd63, 6'd1, 30);
    // hay limit capped at the hay store size
    run_phase(6'd63, 6'd63, 10);
    repeat (ioed_pkg::HAY_MAX + 2) begin
      send_item(ioed_pkg::ACT_APPEND, ioed_pkg::VW'($urandom()), pick_char());
    end
  endtask

  task automatic test_random_search();
    int                      start;
    int                      sel;
    logic [ioed_pkg::RW-1:0] nl;
    logic [ioed_pkg::RW-1:0] md;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) nl = ioed_pkg::RW'($urandom_range(0, 10));
      else if (sel < 85) nl = ioed_pkg::RW'($urandom_range(11, 32));
      else nl = ioed_pkg::RW'($urandom_range(33, 63));
      sel = $urandom_range(0, 99);
      if (sel < 60) md = ioed_pkg::RW'($urandom_range(0, 4));
      else if (sel < 85) md = ioed_pkg::RW'($urandom_range(5, 20));
      else md = ioed_pkg::RW'($urandom_range(21, 63));
      run_phase(nl, md, $urandom_range(40, 120));
    end
  endtask

  initial begin
    int r;
    int c;
    for (r = 0; r < ioed_pkg::NEEDLE_MAX; r++) needle_chars[r] = '0;
    for (r = 0; r < ioed_pkg::HAY_MAX; r++) hay_chars[r] = '0;
    for (r = 0; r <= ioed_pkg::HAY_MAX; r++)
      for (c = 0; c < ioed_pkg::COLS; c++) dist_rows[r][c] = '0;
    hay_len      = 0;
    needle_len_q = '0;
    slack_q      = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_register_extremes();
    test_random_search();

    drain_results();
    if (error_count == 0) begin
      $display("incremental_osa_edit_distance_top_test OK");
    end else begin
      $display("incremental_osa_edit_distance_top_test NOT OK");
    end
    $finish;
  end

endmodule
